// ----- hw/rtl/ssfa_pkg.sv -----
// Shared constants, word types and control structures of the sprite sheet frame animator.
`timescale 1ns / 1ps

package ssfa_pkg;

	// Sizing of the sequence table and of the sheet.
	localparam int SEQ_DEPTH      = 64;
	localparam int MAX_SHEET_SIDE = 16;
	localparam int SEQ_AW         = $clog2(SEQ_DEPTH);

	// Effective sequence length: up to 16 x 16 frames or SEQ_DEPTH entries.
	localparam int LEN_W = 10;

	// Shared restoring divider: widest dividend is counter plus step count.
	localparam int DIV_DVD_W   = 18;
	localparam int DIV_DSR_W   = 16;
	localparam int DIV_SHORT_W = 8;
	localparam int DIV_CNT_W   = $clog2(DIV_DVD_W + 1);

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHEET_COLUMNS   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHEET_ROWS      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SEQUENCE_LENGTH = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_X      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_Y      = 3'd7;

	// Item modes.
	localparam logic [1:0] MODE_TICK    = 2'd0;
	localparam logic [1:0] MODE_WRITE   = 2'd1;
	localparam logic [1:0] MODE_SETPOS  = 2'd2;
	localparam logic [1:0] MODE_RESTART = 2'd3;

	// Input word.
	typedef struct packed {
		logic [1:0]         mode;
		logic [15:0]        delta_time;
		logic [5:0]         entry_index;
		logic [7:0]         entry_frame;
		logic signed [31:0] new_pos_x;
		logic signed [31:0] new_pos_y;
	} item_t;

	// Result word.
	typedef struct packed {
		logic [15:0]        source_x;
		logic [15:0]        source_y;
		logic [7:0]         frame_number;
		logic               animating;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
	} result_t;

	// Which division the shared divider is working on.
	typedef enum logic [1:0] {
		DIV_TIMER,
		DIV_COUNT,
		DIV_INDEX,
		DIV_FRAME
	} div_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     accept;
		logic     exec;
		logic     move;
		logic     div_start;
		logic     div_capture;
		div_sel_t div_sel;
		logic     table_read;
		logic     multiply;
		logic     out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] mode;
		logic       active;
		logic       div_done;
	} stat_t;

endpackage

// ----- hw/rtl/ssfa_div.sv -----
// Iterative restoring divider, one quotient bit per clock cycle.
`timescale 1ns / 1ps

module ssfa_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            short_op,
	input  logic [ssfa_pkg::DIV_DVD_W-1:0]  dividend,
	input  logic [ssfa_pkg::DIV_DSR_W-1:0]  divisor,
	output logic                            done,
	output logic [ssfa_pkg::DIV_DVD_W-1:0]  quotient,
	output logic [ssfa_pkg::DIV_DSR_W-1:0]  remainder
);

	logic [ssfa_pkg::DIV_DVD_W-1:0] quo_q;
	logic [ssfa_pkg::DIV_DSR_W-1:0] rem_q;
	logic [ssfa_pkg::DIV_DSR_W-1:0] dsr_q;
	logic [ssfa_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;

	logic [ssfa_pkg::DIV_DSR_W:0]   rem_sh;
	logic [ssfa_pkg::DIV_DSR_W:0]   rem_diff;
	logic                           fits;
	logic [ssfa_pkg::DIV_DSR_W-1:0] rem_next;

	// One restoring step: shift in the next dividend bit and try to subtract.
	always_comb begin
		rem_sh   = {rem_q, quo_q[ssfa_pkg::DIV_DVD_W-1]};
		rem_diff = rem_sh - {1'b0, dsr_q};
		fits     = (rem_sh >= {1'b0, dsr_q});
		rem_next = fits ? rem_diff[ssfa_pkg::DIV_DSR_W-1:0] : rem_sh[ssfa_pkg::DIV_DSR_W-1:0];
	end

	// Step counter and completion flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= short_op ? ssfa_pkg::DIV_CNT_W'(ssfa_pkg::DIV_SHORT_W)
				                   : ssfa_pkg::DIV_CNT_W'(ssfa_pkg::DIV_DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ssfa_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and partial result registers. A short division left-aligns an
	// 8-bit dividend so that fewer steps are needed.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= short_op
				? {dividend[ssfa_pkg::DIV_SHORT_W-1:0],
				   {(ssfa_pkg::DIV_DVD_W - ssfa_pkg::DIV_SHORT_W){1'b0}}}
				: dividend;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[ssfa_pkg::DIV_DVD_W-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ----- hw/rtl/ssfa_dp.sv -----
// Datapath of the sprite sheet frame animator: registers, table, divider and multipliers.
`timescale 1ns / 1ps

module ssfa_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [ssfa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ssfa_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  ssfa_pkg::item_t                  item_data,
	input  ssfa_pkg::cmd_t                   cmd,
	output ssfa_pkg::stat_t                  stat,
	output ssfa_pkg::result_t                result_data
);

	// Configuration registers.
	logic [15:0]        frame_period_q;
	logic [4:0]         sheet_columns_q;
	logic [4:0]         sheet_rows_q;
	logic [11:0]        frame_width_q;
	logic [11:0]        frame_height_q;
	logic [6:0]         sequence_length_q;
	logic signed [15:0] velocity_x_q;
	logic signed [15:0] velocity_y_q;

	// Animation and position state.
	logic [15:0] timer_q;
	logic [7:0]  counter_q;
	logic [31:0] position_x_q;
	logic [31:0] position_y_q;

	// Per-word working registers.
	ssfa_pkg::item_t    item_q;
	logic signed [32:0] move_x_q;
	logic signed [32:0] move_y_q;
	logic [16:0]        steps_q;
	logic [7:0]         idx_q;
	logic [7:0]         table_rd_q;
	logic [7:0]         fnum_q;
	logic [4:0]         col_q;
	logic [7:0]         row_q;
	logic [16:0]        org_x_q;
	logic [19:0]        org_y_q;
	ssfa_pkg::result_t  result_q;

	logic [7:0] seq_table [ssfa_pkg::SEQ_DEPTH];

	// Derived configuration.
	logic [4:0]                    cols_c;
	logic [4:0]                    rows_c;
	logic [9:0]                    sheet_frames;
	logic [ssfa_pkg::LEN_W-1:0]    loaded_len;
	logic [ssfa_pkg::LEN_W-1:0]    seq_len;
	logic                          active;

	// Division operands and results.
	logic [16:0]                      timer_sum;
	logic [ssfa_pkg::DIV_DVD_W-1:0]   count_sum;
	logic [7:0]                       fnum_next;
	logic [ssfa_pkg::DIV_DVD_W-1:0]   div_dvd;
	logic [ssfa_pkg::DIV_DSR_W-1:0]   div_dsr;
	logic                             div_short;
	logic                             div_done;
	logic [ssfa_pkg::DIV_DVD_W-1:0]   div_quo;
	logic [ssfa_pkg::DIV_DSR_W-1:0]   div_rem;

	// Movement.
	logic signed [32:0] move_x;
	logic signed [32:0] move_y;
	logic signed [32:0] rnd_x;
	logic signed [32:0] rnd_y;
	logic [31:0]        step_x;
	logic [31:0]        step_y;

	// Table addresses.
	logic [ssfa_pkg::SEQ_AW-1:0] wr_addr;
	logic [ssfa_pkg::SEQ_AW-1:0] rd_addr;
	logic                        wr_in_range;

	// A side of zero counts as one, and a side above the limit is clamped.
	function automatic logic [4:0] side_clamp(input logic [4:0] v);
		logic [4:0] r;
		r = v;
		if (v == 5'd0) begin
			r = 5'd1;
		end else if (32'(v) > ssfa_pkg::MAX_SHEET_SIDE) begin
			r = 5'(ssfa_pkg::MAX_SHEET_SIDE);
		end
		return r;
	endfunction

	// Effective sequence length and the animation enable.
	always_comb begin
		cols_c       = side_clamp(sheet_columns_q);
		rows_c       = side_clamp(sheet_rows_q);
		sheet_frames = 10'(cols_c) * 10'(rows_c);
		if (ssfa_pkg::LEN_W'(sequence_length_q) > ssfa_pkg::LEN_W'(ssfa_pkg::SEQ_DEPTH)) begin
			loaded_len = ssfa_pkg::LEN_W'(ssfa_pkg::SEQ_DEPTH);
		end else begin
			loaded_len = ssfa_pkg::LEN_W'(sequence_length_q);
		end
		seq_len = (loaded_len != '0) ? loaded_len : ssfa_pkg::LEN_W'(sheet_frames);
		active  = (frame_period_q != 16'd0) && (seq_len > ssfa_pkg::LEN_W'(1));
	end

	// Operand selection for the shared divider.
	always_comb begin
		timer_sum = {1'b0, timer_q} + {1'b0, item_q.delta_time};
		count_sum = ssfa_pkg::DIV_DVD_W'(counter_q) + ssfa_pkg::DIV_DVD_W'(steps_q);
		fnum_next = (loaded_len != '0) ? table_rd_q : idx_q;
		case (cmd.div_sel)
			ssfa_pkg::DIV_TIMER: begin
				div_dvd   = ssfa_pkg::DIV_DVD_W'(timer_sum);
				div_dsr   = frame_period_q;
				div_short = 1'b0;
			end
			ssfa_pkg::DIV_COUNT: begin
				div_dvd   = count_sum;
				div_dsr   = ssfa_pkg::DIV_DSR_W'(seq_len);
				div_short = 1'b0;
			end
			ssfa_pkg::DIV_INDEX: begin
				div_dvd   = ssfa_pkg::DIV_DVD_W'(counter_q);
				div_dsr   = ssfa_pkg::DIV_DSR_W'(seq_len);
				div_short = 1'b1;
			end
			ssfa_pkg::DIV_FRAME: begin
				div_dvd   = ssfa_pkg::DIV_DVD_W'(fnum_next);
				div_dsr   = ssfa_pkg::DIV_DSR_W'(cols_c);
				div_short = 1'b1;
			end
			default: begin
				div_dvd   = '0;
				div_dsr   = ssfa_pkg::DIV_DSR_W'(1);
				div_short = 1'b1;
			end
		endcase
	end

	ssfa_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.short_op  (div_short),
		.dividend  (div_dvd),
		.divisor   (div_dsr),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Movement step: velocity times elapsed time in Q8.24, rounded half up to Q16.16.
	always_comb begin
		move_x = velocity_x_q * $signed({1'b0, item_q.delta_time});
		move_y = velocity_y_q * $signed({1'b0, item_q.delta_time});
		rnd_x  = move_x_q + 33'sd128;
		rnd_y  = move_y_q + 33'sd128;
		step_x = {{7{rnd_x[32]}}, rnd_x[32:8]};
		step_y = {{7{rnd_y[32]}}, rnd_y[32:8]};
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_period_q    <= 16'd0;
			sheet_columns_q   <= 5'd1;
			sheet_rows_q      <= 5'd1;
			frame_width_q     <= 12'd1;
			frame_height_q    <= 12'd1;
			sequence_length_q <= 7'd0;
			velocity_x_q      <= 16'sd0;
			velocity_y_q      <= 16'sd0;
		end else if (cfg_write) begin
			case (cfg_index)
				ssfa_pkg::REG_FRAME_PERIOD:    frame_period_q    <= cfg_data;
				ssfa_pkg::REG_SHEET_COLUMNS:   sheet_columns_q   <= cfg_data[4:0];
				ssfa_pkg::REG_SHEET_ROWS:      sheet_rows_q      <= cfg_data[4:0];
				ssfa_pkg::REG_FRAME_WIDTH:     frame_width_q     <= cfg_data[11:0];
				ssfa_pkg::REG_FRAME_HEIGHT:    frame_height_q    <= cfg_data[11:0];
				ssfa_pkg::REG_SEQUENCE_LENGTH: sequence_length_q <= cfg_data[6:0];
				ssfa_pkg::REG_VELOCITY_X:      velocity_x_q      <= $signed(cfg_data);
				ssfa_pkg::REG_VELOCITY_Y:      velocity_y_q      <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// Timer, frame counter and position state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q      <= 16'd0;
			counter_q    <= 8'd0;
			position_x_q <= 32'd0;
			position_y_q <= 32'd0;
		end else begin
			if (cmd.exec) begin
				case (item_q.mode)
					ssfa_pkg::MODE_SETPOS: begin
						position_x_q <= item_q.new_pos_x;
						position_y_q <= item_q.new_pos_y;
					end
					ssfa_pkg::MODE_RESTART: begin
						timer_q   <= 16'd0;
						counter_q <= 8'd0;
					end
					default: ;
				endcase
			end
			if (cmd.move) begin
				position_x_q <= position_x_q + step_x;
				position_y_q <= position_y_q + step_y;
			end
			if (cmd.div_capture && (cmd.div_sel == ssfa_pkg::DIV_TIMER)) begin
				timer_q <= div_rem;
			end
			if (cmd.div_capture && (cmd.div_sel == ssfa_pkg::DIV_COUNT)) begin
				counter_q <= div_rem[7:0];
			end
		end
	end

	// Working registers for one word.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q <= item_data;
		end
		if (cmd.exec) begin
			move_x_q <= move_x;
			move_y_q <= move_y;
		end
		if (cmd.div_capture) begin
			case (cmd.div_sel)
				ssfa_pkg::DIV_TIMER: steps_q <= div_quo[16:0];
				ssfa_pkg::DIV_INDEX: idx_q   <= div_rem[7:0];
				ssfa_pkg::DIV_FRAME: begin
					col_q <= div_rem[4:0];
					row_q <= div_quo[7:0];
				end
				default: ;
			endcase
		end
		if (cmd.div_start && (cmd.div_sel == ssfa_pkg::DIV_FRAME)) begin
			fnum_q <= fnum_next;
		end
		if (cmd.multiply) begin
			org_x_q <= 17'(col_q) * 17'(frame_width_q);
			org_y_q <= 20'(row_q) * 20'(frame_height_q);
		end
	end

	// Sequence table: written by table-write words, read once per animated word.
	always_comb begin
		wr_addr     = ssfa_pkg::SEQ_AW'(item_q.entry_index);
		rd_addr     = ssfa_pkg::SEQ_AW'(idx_q);
		wr_in_range = (32'(item_q.entry_index) < ssfa_pkg::SEQ_DEPTH);
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && (item_q.mode == ssfa_pkg::MODE_WRITE) && wr_in_range) begin
			seq_table[wr_addr] <= item_q.entry_frame;
		end
		if (cmd.table_read) begin
			table_rd_q <= seq_table[rd_addr];
		end
	end

	// Result register: origins saturate at 16 bits, and an idle sheet shows origin zero.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result_q.pos_x <= position_x_q;
			result_q.pos_y <= position_y_q;
			if (active) begin
				result_q.source_x     <= (org_x_q > 17'(16'hFFFF)) ? 16'hFFFF : org_x_q[15:0];
				result_q.source_y     <= (org_y_q > 20'(16'hFFFF)) ? 16'hFFFF : org_y_q[15:0];
				result_q.frame_number <= fnum_q;
				result_q.animating    <= 1'b1;
			end else begin
				result_q.source_x     <= 16'd0;
				result_q.source_y     <= 16'd0;
				result_q.frame_number <= 8'd0;
				result_q.animating    <= 1'b0;
			end
		end
	end

	assign result_data   = result_q;
	assign stat.mode     = item_q.mode;
	assign stat.active   = active;
	assign stat.div_done = div_done;

endmodule

// ----- hw/rtl/ssfa_ctrl.sv -----
// Controller of the sprite sheet frame animator: sequences one word through the datapath.
`timescale 1ns / 1ps

module ssfa_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	output logic            result_valid,
	input  logic            result_ready,
	input  ssfa_pkg::stat_t stat,
	output ssfa_pkg::cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_MOVE,
		S_TDIV,
		S_TWAIT,
		S_CDIV,
		S_CWAIT,
		S_IDIV,
		S_IWAIT,
		S_READ,
		S_FDIV,
		S_FWAIT,
		S_MUL,
		S_OUT
	} state_t;

	state_t state_q;
	logic   result_valid_q;
	logic   out_free;

	assign out_free = !result_valid_q || result_ready;

	// State and the result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= (stat.mode == ssfa_pkg::MODE_TICK) ? S_MOVE : S_IDIV;
				end
				S_MOVE: begin
					state_q <= stat.active ? S_TDIV : S_IDIV;
				end
				S_TDIV: state_q <= S_TWAIT;
				S_TWAIT: begin
					if (stat.div_done) begin
						state_q <= S_CDIV;
					end
				end
				S_CDIV: state_q <= S_CWAIT;
				S_CWAIT: begin
					if (stat.div_done) begin
						state_q <= S_IDIV;
					end
				end
				S_IDIV: begin
					state_q <= stat.active ? S_IWAIT : S_OUT;
				end
				S_IWAIT: begin
					if (stat.div_done) begin
						state_q <= S_READ;
					end
				end
				S_READ: state_q <= S_FDIV;
				S_FDIV: state_q <= S_FWAIT;
				S_FWAIT: begin
					if (stat.div_done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						result_valid_q <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Command decode.
	always_comb begin
		cmd             = '0;
		cmd.div_sel     = ssfa_pkg::DIV_TIMER;
		cmd.accept      = (state_q == S_IDLE) && item_valid;
		cmd.exec        = (state_q == S_EXEC);
		cmd.move        = (state_q == S_MOVE);
		cmd.table_read  = (state_q == S_READ);
		cmd.multiply    = (state_q == S_MUL);
		cmd.out_load    = (state_q == S_OUT) && out_free;
		case (state_q)
			S_TDIV: begin
				cmd.div_sel   = ssfa_pkg::DIV_TIMER;
				cmd.div_start = 1'b1;
			end
			S_TWAIT: begin
				cmd.div_sel     = ssfa_pkg::DIV_TIMER;
				cmd.div_capture = stat.div_done;
			end
			S_CDIV: begin
				cmd.div_sel   = ssfa_pkg::DIV_COUNT;
				cmd.div_start = 1'b1;
			end
			S_CWAIT: begin
				cmd.div_sel     = ssfa_pkg::DIV_COUNT;
				cmd.div_capture = stat.div_done;
			end
			S_IDIV: begin
				cmd.div_sel   = ssfa_pkg::DIV_INDEX;
				cmd.div_start = stat.active;
			end
			S_IWAIT: begin
				cmd.div_sel     = ssfa_pkg::DIV_INDEX;
				cmd.div_capture = stat.div_done;
			end
			S_FDIV: begin
				cmd.div_sel   = ssfa_pkg::DIV_FRAME;
				cmd.div_start = 1'b1;
			end
			S_FWAIT: begin
				cmd.div_sel     = ssfa_pkg::DIV_FRAME;
				cmd.div_capture = stat.div_done;
			end
			default: ;
		endcase
	end

	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = result_valid_q;

endmodule

// ----- hw/rtl/sprite_sheet_frame_animator_core.sv -----
// Top level of the sprite sheet frame animator.
// The block takes one word at a time and returns one result word for each. The time a word
// takes is set by the single shared restoring divider, which produces one quotient bit per
// cycle: a tick that advances an active animation runs an 18-step division of the timer by
// the frame period and an 18-step reduction of the frame counter by the sequence length,
// every animated word then runs two 8-step divisions for the frame index and for the sheet
// column and row, and with animation off a word runs no division. A new word is taken as
// soon as the previous result sits in the output register, even if it has not yet been
// collected. The sequence table holds undefined data after reset until written.
`timescale 1ns / 1ps

module sprite_sheet_frame_animator_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  ssfa_pkg::item_t                 item_data,
	output logic                            result_valid,
	input  logic                            result_ready,
	output ssfa_pkg::result_t               result_data,
	input  logic                            cfg_write,
	input  logic [ssfa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ssfa_pkg::CFG_DATA_W-1:0] cfg_data
);

	ssfa_pkg::cmd_t  cmd;
	ssfa_pkg::stat_t stat;

	// Sequencing of each word.
	ssfa_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	// Registers, table and arithmetic.
	ssfa_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.item_data   (item_data),
		.cmd         (cmd),
		.stat        (stat),
		.result_data (result_data)
	);

endmodule

// ----- hw/rtl/ssfa_checker.sv -----
// Port-level assertions of the sprite sheet frame animator, bound to the top level.
`timescale 1ns / 1ps

module ssfa_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_ready,
	input ssfa_pkg::item_t   item_data,
	input logic              result_valid,
	input logic              result_ready,
	input ssfa_pkg::result_t result_data
);

	// A result word waiting to be taken stays put.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_data))
		else $error("result word changed or dropped while stalled");

	// Only one word is in progress at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("input accepted again while a word was in progress");

	// Delivering a result frees the block for the next word.
	a_ready_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> item_ready)
		else $error("result delivered but input not ready");

	// With animation off the result shows frame zero at origin zero.
	a_idle_origin: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_data.animating |->
			result_data.source_x == 16'd0 && result_data.source_y == 16'd0 &&
			result_data.frame_number == 8'd0)
		else $error("non-zero frame origin while animation is off");

endmodule

bind sprite_sheet_frame_animator_core ssfa_checker u_checker (.*);
